/* sv/hprc_pkg.sv */
`timescale 1ns / 1ps

package hprc_pkg;

    localparam int MSG_BYTES_DEF    = 512;
    localparam int PACKET_BYTES_DEF = 62;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;

    typedef enum logic [1:0] {
        ST_DROP = 2'd0,
        ST_MORE = 2'd1,
        ST_DONE = 2'd2
    } status_t;

    typedef struct packed {
        logic [3:0] total_index;
        logic [3:0] packet_index;
        logic [5:0] data_bytes;
        logic       ack_request;
        logic       toggle_bit;
        logic       reset_marker;
    } hdr_t;

    typedef struct packed {
        status_t    status;
        logic [8:0] write_offset;
        logic [9:0] message_length;
        logic       echo_ack;
    } res_t;

    typedef struct packed {
        logic       expect_flip;
        logic [4:0] expected_index;
        logic [3:0] last_index;
    } seq_t;

endpackage

/* sv/hprc_decide.sv */
`timescale 1ns / 1ps

module hprc_decide #(
    parameter int MSG_BYTES    = hprc_pkg::MSG_BYTES_DEF,
    parameter int PACKET_BYTES = hprc_pkg::PACKET_BYTES_DEF,
    parameter int FILL_W       = $clog2(MSG_BYTES + 1)
) (
    input  hprc_pkg::hdr_t      hdr,
    input  hprc_pkg::seq_t      seq,
    input  logic [FILL_W-1:0]   fill,
    output hprc_pkg::res_t      res,
    output hprc_pkg::seq_t      seq_next,
    output logic [FILL_W-1:0]   fill_next
);
    import hprc_pkg::*;

    localparam int SUM_W = FILL_W + 1;
    localparam int EXT_W = (SUM_W > 10) ? SUM_W : 10;
    localparam logic [5:0] LEN_MAX = 6'(PACKET_BYTES);

    logic [5:0]        len_c;
    logic              flip_bad;
    logic              order_bad;
    logic              first_pkt;
    logic [3:0]        last_eff;
    logic [FILL_W-1:0] fill_base;
    logic [SUM_W-1:0]  sum;
    logic              overflow;
    logic [EXT_W-1:0]  base_ext;
    logic [EXT_W-1:0]  sum_ext;

    always_comb
    begin
        len_c     = (hdr.data_bytes > LEN_MAX) ? LEN_MAX : hdr.data_bytes;
        flip_bad  = hdr.toggle_bit != seq.expect_flip;
        order_bad = (seq.expected_index != 5'd0)
                    && ({1'b0, hdr.packet_index} != seq.expected_index);
        first_pkt = hdr.packet_index == 4'd0;
        // first packet latches the total and restarts the fill
        last_eff  = first_pkt ? hdr.total_index : seq.last_index;
        fill_base = first_pkt ? '0 : fill;
        sum       = {1'b0, fill_base} + SUM_W'(len_c);
        overflow  = sum > SUM_W'(MSG_BYTES);
        base_ext  = EXT_W'(fill_base);
        sum_ext   = EXT_W'(sum);

        seq_next  = seq;
        fill_next = fill;
        res       = '{status: ST_DROP, write_offset: '0, message_length: '0, echo_ack: 1'b0};

        if (hdr.reset_marker)
        begin
            seq_next.expect_flip    = 1'b0;
            seq_next.expected_index = '0;
            fill_next               = '0;
        end
        else if (flip_bad || order_bad)
        begin
            seq_next.expected_index = '0;
            fill_next               = '0;
        end
        else
        begin
            seq_next.last_index = last_eff;
            if (overflow)
            begin
                seq_next.expected_index = '0;
                fill_next               = '0;
            end
            else if (hdr.packet_index == last_eff)
            begin
                seq_next.expect_flip    = ~seq.expect_flip;
                seq_next.expected_index = '0;
                fill_next               = '0;
                res.status              = ST_DONE;
                res.write_offset        = base_ext[8:0];
                res.message_length      = sum_ext[9:0];
                res.echo_ack            = hdr.ack_request;
            end
            else
            begin
                if (seq.expected_index != 5'd31)
                    seq_next.expected_index = seq.expected_index + 5'd1;
                fill_next        = sum[FILL_W-1:0];
                res.status       = ST_MORE;
                res.write_offset = base_ext[8:0];
            end
        end
    end

endmodule

/* sv/hid_packet_reassembly_checker_top.sv */
`timescale 1ns / 1ps

// HID packet reassembly checker.
// Slave channel: one beat per received packet header.
//   s_tdata holds toggle_bit, ack_request, data_bytes, packet_index,
//   total_index; s_tuser carries reset_marker.
// Master channel: one beat per header with the decision.
//   m_tuser carries status (0 drop, 1 more to come, 2 complete);
//   m_tdata holds write_offset, message_length, echo_ack.
// A header beat is captured in an input register; the decision logic
// reads it with the sequence state, updates the state and loads the
// result register that drives the result beat, once that register is
// free or its beat leaves. One header per cycle is sustained while
// m_tready stays high; the decision loop over the sequence state is
// combinational between its registers.
// When m_tready is low the result register holds, an empty input register
// still takes one more beat, then s_tready drops until the result leaves.
// Reset empties both registers and clears the flip expectation, expected
// packet index, latched last index and fill count.

module hid_packet_reassembly_checker_top #(
    parameter int MSG_BYTES    = hprc_pkg::MSG_BYTES_DEF,
    parameter int PACKET_BYTES = hprc_pkg::PACKET_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] toggle_bit, [1] ack_request, [7:2] data_bytes,
    // [11:8] packet_index, [15:12] total_index
    input  logic [hprc_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] reset_marker
    input  logic [hprc_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [8:0] write_offset, [18:9] message_length, [19] echo_ack, [23:20] zero
    output logic [hprc_pkg::OUT_DATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [hprc_pkg::OUT_USER_W-1:0] m_tuser
);
    import hprc_pkg::*;

    localparam int FILL_W = $clog2(MSG_BYTES + 1);

    logic              in_valid_reg;
    hdr_t              hdr_reg;
    logic              out_valid_reg;
    res_t              res_reg;
    seq_t              seq_reg;
    seq_t              seq_next;
    logic [FILL_W-1:0] fill_count_reg;
    logic [FILL_W-1:0] fill_count_next;
    res_t              res_next;
    logic              advance;
    logic              in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    hprc_decide #(
        .MSG_BYTES    (MSG_BYTES),
        .PACKET_BYTES (PACKET_BYTES),
        .FILL_W       (FILL_W)
    ) u_decide (
        .hdr       (hdr_reg),
        .seq       (seq_reg),
        .fill      (fill_count_reg),
        .res       (res_next),
        .seq_next  (seq_next),
        .fill_next (fill_count_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            seq_reg        <= '0;
            fill_count_reg <= '0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                seq_reg        <= seq_next;
                fill_count_reg <= fill_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hdr_reg.reset_marker <= s_tuser[0];
            hdr_reg.toggle_bit   <= s_tdata[0];
            hdr_reg.ack_request  <= s_tdata[1];
            hdr_reg.data_bytes   <= s_tdata[7:2];
            hdr_reg.packet_index <= s_tdata[11:8];
            hdr_reg.total_index  <= s_tdata[15:12];
        end
        if (advance)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {4'd0, res_reg.echo_ack, res_reg.message_length, res_reg.write_offset};

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_W'(MSG_BYTES))
        else $error("fill count beyond message buffer");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(fill_count_reg) && $stable(seq_reg)))
        else $error("sequence state moved while result stalled");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_next.status != ST_MORE) |=>
            (fill_count_reg == '0 && seq_reg.expected_index == 5'd0))
        else $error("reassembly not restarted after drop or completion");

    a_echo_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[19]) |-> (m_tuser == ST_DONE))
        else $error("echo outside completion");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_DROP) |-> (m_tdata[18:0] == 19'd0))
        else $error("dropped result carries data");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import hprc_pkg::*;

    localparam int MSG_BYTES    = MSG_BYTES_DEF;
    localparam int PACKET_BYTES = PACKET_BYTES_DEF;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_HEADERS = 205;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    // predicted sequence state
    logic       seq_flip;
    logic [4:0] seq_next_idx;
    logic [3:0] seq_last_idx;
    int         seq_fill;

    res_t pending_decisions[$];
    int   mismatch_count = 0;
    int   headers_sent = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;

    hid_packet_reassembly_checker_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    function automatic void note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", what);
    endfunction

    // Decision for one header; updates the predicted sequence state.
    function automatic res_t judge_header(input hdr_t h);
        res_t r;
        int   len;
        bit   drop;
        r = '0;
        r.status = ST_DROP;
        drop = 1'b0;
        len = (h.data_bytes > PACKET_BYTES) ? PACKET_BYTES : int'(h.data_bytes);
        if (h.reset_marker)
        begin
            seq_flip = 1'b0;
            drop = 1'b1;
        end
        else if (h.toggle_bit != seq_flip)
            drop = 1'b1;
        else if (seq_next_idx != 0 && {1'b0, h.packet_index} != seq_next_idx)
            drop = 1'b1;
        else
        begin
            if (h.packet_index == 0)
            begin
                seq_last_idx = h.total_index;
                seq_fill = 0;
            end
            if (seq_fill + len > MSG_BYTES)
                drop = 1'b1;
            else
            begin
                r.write_offset = 9'(seq_fill);
                seq_fill += len;
                if (seq_next_idx < 31)
                    seq_next_idx++;
                if (h.packet_index == seq_last_idx)
                begin
                    seq_flip = ~seq_flip;
                    r.status = ST_DONE;
                    r.message_length = 10'(seq_fill);
                    r.echo_ack = h.ack_request;
                    seq_fill = 0;
                    seq_next_idx = '0;
                end
                else
                    r.status = ST_MORE;
            end
        end
        if (drop)
        begin
            seq_fill = 0;
            seq_next_idx = '0;
        end
        return r;
    endfunction

    function automatic hdr_t make_header(input bit marker, input bit flip, input bit ack,
                                         input int unsigned len, input int unsigned pidx,
                                         input int unsigned tidx);
        hdr_t h;
        h.reset_marker = marker;
        h.toggle_bit   = flip;
        h.ack_request  = ack;
        h.data_bytes   = 6'(len);
        h.packet_index = 4'(pidx);
        h.total_index  = 4'(tidx);
        return h;
    endfunction

    function automatic int unsigned pick_len();
        case ($urandom_range(3))
            0: return PACKET_BYTES;
            1: return 63;
            default: return $urandom_range(63);
        endcase
    endfunction

    // Called right after the previous beat was taken, so s_tvalid gets one NBA per step.
    task automatic send_header(input hdr_t h);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {h.total_index, h.packet_index, h.data_bytes, h.ack_request, h.toggle_bit};
        s_tuser  <= h.reset_marker;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_decisions.push_back(judge_header(h));
        headers_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_decisions.size() == 0)
                note_mismatch($sformatf("result beat with no header pending: st=%0d data=%0h",
                                        m_tuser, m_tdata));
            else
            begin
                want = pending_decisions.pop_front();
                if (m_tuser != want.status || m_tdata[8:0] != want.write_offset
                    || m_tdata[18:9] != want.message_length || m_tdata[19] != want.echo_ack
                    || m_tdata[23:20] != 4'd0)
                    note_mismatch({
                        $sformatf("mismatch: want st=%0d off=%0d len=%0d echo=%0d, ",
                                  want.status, want.write_offset, want.message_length,
                                  want.echo_ack),
                        $sformatf("got st=%0d off=%0d len=%0d echo=%0d pad=%0h",
                                  m_tuser, m_tdata[8:0], m_tdata[18:9], m_tdata[19],
                                  m_tdata[23:20])});
            end
        end
    end

    // Mostly well-formed messages with random content, now and then one beat broken.
    task automatic send_random_message();
        int unsigned last_pkt;
        bit          full_fit;
        hdr_t        h;
        full_fit = ($urandom_range(11) == 0);
        if (full_fit)
            last_pkt = 8;
        else if ($urandom_range(3) == 0)
            last_pkt = $urandom_range(15);
        else
            last_pkt = $urandom_range(3);
        for (int i = 0; i <= last_pkt; i++)
        begin
            // 8 x 62 + 16 fills the buffer exactly
            h = make_header(1'b0, seq_flip, 1'($urandom_range(1)),
                            full_fit ? ((i == 8) ? 16 : PACKET_BYTES) : pick_len(),
                            i, (i == 0) ? last_pkt : $urandom_range(15));
            if ($urandom_range(19) == 0)
            begin
                case ($urandom_range(3))
                    0: h.reset_marker = 1'b1;
                    1: h.toggle_bit = ~h.toggle_bit;
                    2: h.packet_index = 4'($urandom_range(15));
                    default: h.packet_index = h.packet_index + 4'd1;
                endcase
            end
            send_header(h);
        end
    endtask

    task automatic run_traffic(input int count);
        int target;
        target = headers_sent + count;
        while (headers_sent < target)
        begin
            if ($urandom_range(4) == 0)
                send_header(make_header($urandom_range(7) == 0, 1'($urandom_range(1)),
                                        1'($urandom_range(1)), $urandom_range(63),
                                        $urandom_range(15), $urandom_range(15)));
            else
                send_random_message();
        end
    endtask

    task automatic test_special_cases();
        // marker with every other field at its top value
        send_header(make_header(1'b1, 1'b1, 1'b1, 63, 15, 15));
        // flip mismatch
        send_header(make_header(1'b0, 1'b1, 1'b0, 10, 0, 0));
        // one-packet message, oversized payload clipped
        send_header(make_header(1'b0, 1'b0, 1'b1, 63, 0, 0));
        // three packets, empty middle payload
        send_header(make_header(1'b0, 1'b1, 1'b1, 62, 0, 2));
        send_header(make_header(1'b0, 1'b1, 1'b1, 0, 1, 0));
        send_header(make_header(1'b0, 1'b1, 1'b0, 62, 2, 7));
        // out of order
        send_header(make_header(1'b0, 1'b0, 1'b0, 10, 0, 3));
        send_header(make_header(1'b0, 1'b0, 1'b0, 10, 2, 3));
        // start without a first packet, judged against held last index
        send_header(make_header(1'b0, 1'b0, 1'b1, 5, 3, 9));
        // index past the held last: next index becomes 1, then packet 0 does not match
        send_header(make_header(1'b0, 1'b1, 1'b1, 1, 15, 0));
        send_header(make_header(1'b0, 1'b1, 1'b0, 1, 0, 0));
        // overflow on the ninth packet, 17 bytes after eight full packets
        for (int i = 0; i < 8; i++)
            send_header(make_header(1'b0, 1'b1, 1'(i % 2), PACKET_BYTES, i, 15));
        send_header(make_header(1'b0, 1'b1, 1'b1, 17, 8, 15));
        drain_results();
    endtask

    task automatic test_back_to_back();
        send_idle_pct = 0;
        stall_pct = 0;
        run_traffic(PHASE_HEADERS);
        drain_results();
    endtask

    task automatic test_sender_gaps();
        send_idle_pct = 75;
        stall_pct = 0;
        run_traffic(PHASE_HEADERS);
        drain_results();
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct = 0;
        stall_pct = 75;
        run_traffic(PHASE_HEADERS);
        drain_results();
    endtask

    task automatic test_mixed_idling();
        send_idle_pct = 30;
        stall_pct = 30;
        run_traffic(PHASE_HEADERS / 2);
        drain_results();
        run_traffic(PHASE_HEADERS / 2);
        drain_results();
    endtask

    initial
    begin
        seq_flip = 1'b0;
        seq_next_idx = '0;
        seq_last_idx = '0;
        seq_fill = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_cases();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        if (mismatch_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
